/* design/kavs_pkg.sv */
// ----------------------------------------------------------------------------
// kavs_pkg: shared types and constants of the key auto-repeat volume stepper
// Key codes, register indexes, level limits and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package kavs_pkg;

	localparam int MAX_LEVEL = 20;
	localparam int LEVEL_W   = 5;
	localparam int PCT_W     = 7;
	localparam int TIME_W    = 32;
	localparam int DELAY_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [9:0] KEY_UP       = 10'd115;
	localparam logic [9:0] KEY_DOWN     = 10'd114;
	localparam logic [9:0] KEY_MENU     = 10'd316;
	localparam logic [9:0] KEY_MENU_TWO = 10'd314;

	localparam logic [4:0] EV_TYPE_KEY = 5'd1;

	localparam logic [1:0] VAL_RELEASED = 2'd0;
	localparam logic [1:0] VAL_PRESSED  = 2'd1;
	localparam logic [1:0] VAL_REPEAT   = 2'd2;
	localparam logic [1:0] VAL_IGNORED  = 2'd3;

	localparam logic FUNC_KEY  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic DIR_UP   = 1'b0;
	localparam logic DIR_DOWN = 1'b1;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [PCT_W-1:0]   pct_t;

	localparam level_t LEVEL_MAX   = level_t'(MAX_LEVEL);
	localparam level_t LEVEL_RESET = (10 > MAX_LEVEL) ? level_t'(MAX_LEVEL) : level_t'(10);

	localparam logic [DELAY_W-1:0] INITIAL_DELAY_RESET = 16'd300;
	localparam logic [DELAY_W-1:0] REPEAT_PERIOD_RESET = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_DELAY = 2'd0,
		CFG_REPEAT_PERIOD = 2'd1,
		CFG_START_VOLUME  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic   direction;
		level_t level;
		pct_t   percent;
		logic   last;
	} res_t;

	// up to two results per tick, in delivery order
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	// select from a table of constant quotients, one entry per level code
	function automatic pct_t level_pct(input level_t lv);
		pct_t p;
		p = '0;
		for (int i = 0; i < (1 << LEVEL_W); i++) begin
			if (lv == level_t'(i)) begin
				p = pct_t'((i * 100) / MAX_LEVEL);
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

/* design/kavs_in_if.sv */
// ----------------------------------------------------------------------------
// kavs_in_if: key event / poll tick channel
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
`default_nettype none

interface kavs_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [4:0]  event_type;
	logic [9:0]  key_code;
	logic [1:0]  key_value;
	logic [31:0] now_ms;

	modport source (output valid, func, event_type, key_code, key_value, now_ms,
		input ready);
	modport sink (input valid, func, event_type, key_code, key_value, now_ms,
		output ready);
endinterface

`default_nettype wire

/* design/kavs_out_if.sv */
// ----------------------------------------------------------------------------
// kavs_out_if: level step result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface kavs_out_if;
	logic       valid;
	logic       ready;
	logic       direction;
	logic [4:0] level;
	logic [6:0] percent;
	logic       last;

	modport source (output valid, direction, level, percent, last, input ready);
	modport sink (input valid, direction, level, percent, last, output ready);
endinterface

`default_nettype wire

/* design/kavs_cfg_if.sv */
// ----------------------------------------------------------------------------
// kavs_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kavs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/key_autorepeat_volume_stepper.sv */
// ----------------------------------------------------------------------------
// key_autorepeat_volume_stepper: key auto-repeat up/down level counter
// Key events update key flags; poll ticks step a saturating level.
//
//   channel     dir  payload                                      words
//   key_in      in   func, event_type, key_code, key_value, now   1 / cycle
//   result_out  out  direction, level, percent, last              1 / cycle
//   cfg         in   index, data                                  1 / cycle
//
// An input word is taken every cycle while the result queue has room for two
// words; a tick's results are written from the input register into the result
// queue, which drives result_out, once the queue has room for them.
// A tick giving two results hands them out in turn on the single output port.
// arst_n clears key state, loads level 10 and the default delays.
// A stall on result_out holds the queue; key_in stalls once it fills past two.
// cfg is held off while an input word waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module key_autorepeat_volume_stepper
	import kavs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	kavs_in_if.sink     key_in,
	kavs_out_if.source  result_out,
	kavs_cfg_if.sink    cfg
);

	push_t push;
	logic  room;

	kavs_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.key_in (key_in),
		.cfg    (cfg),
		.room   (room),
		.push   (push)
	);

	kavs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.result_out (result_out)
	);

endmodule

`default_nettype wire

/* design/kavs_step.sv */
// ----------------------------------------------------------------------------
// kavs_step: input register, key state and step evaluation
// Holds the key flags, deadlines, level and configuration; turns one word
// into zero, one or two result words per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module kavs_step
	import kavs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	kavs_in_if.sink     key_in,
	kavs_cfg_if.sink    cfg,
	input  wire logic   room,
	output push_t       push
);

	logic              valid_s1;
	logic              func_s1;
	logic [4:0]        etype_s1;
	logic [9:0]        code_s1;
	logic [1:0]        val_s1;
	logic [TIME_W-1:0] now_s1;

	logic [DELAY_W-1:0] init_delay_q;
	logic [DELAY_W-1:0] period_q;

	logic              menu_held_q, menu_two_held_q;
	logic              up_held_q, up_fresh_q, down_held_q, down_fresh_q;
	logic [TIME_W-1:0] up_dl_q, down_dl_q;
	level_t            level_q;

	logic   adv;
	logic   ev_ok, on, blocked;
	logic   up_due, down_due, up_emit, down_emit;
	level_t lvl_up, lvl_dn;
	res_t   r_up, r_dn;
	logic [TIME_W-1:0] arm_dl;
	level_t start_lvl;

	assign adv          = valid_s1 && room;
	assign key_in.ready = !valid_s1 || room;
	// hold register writes off while a word waits in the input register
	assign cfg.ready    = !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.valid && key_in.ready) begin
			func_s1  <= key_in.func;
			etype_s1 <= key_in.event_type;
			code_s1  <= key_in.key_code;
			val_s1   <= key_in.key_value;
			now_s1   <= key_in.now_ms;
		end
	end

	// evaluation of the word in the input register
	always_comb begin
		ev_ok     = (etype_s1 == EV_TYPE_KEY) && (val_s1 != VAL_IGNORED);
		on        = (val_s1 != VAL_RELEASED);
		arm_dl    = now_s1 + TIME_W'(init_delay_q);
		blocked   = menu_held_q || menu_two_held_q;
		up_due    = up_fresh_q || (up_held_q && (now_s1 >= up_dl_q));
		down_due  = down_fresh_q || (down_held_q && (now_s1 >= down_dl_q));
		up_emit   = up_due && !blocked;
		down_emit = down_due && !blocked;
		lvl_up    = level_q;
		if (up_emit && level_q < LEVEL_MAX) begin
			lvl_up = level_q + level_t'(1);
		end
		lvl_dn = lvl_up;
		if (down_emit && lvl_up != '0) begin
			lvl_dn = lvl_up - level_t'(1);
		end
		r_up = '{direction: DIR_UP, level: lvl_up, percent: level_pct(lvl_up),
			last: !down_emit};
		r_dn = '{direction: DIR_DOWN, level: lvl_dn, percent: level_pct(lvl_dn),
			last: 1'b1};
		start_lvl = (cfg.data[LEVEL_W-1:0] > LEVEL_MAX) ? LEVEL_MAX
			: cfg.data[LEVEL_W-1:0];
	end

	always_comb begin
		push.cnt = 2'd0;
		push.r0  = r_up;
		push.r1  = r_dn;
		if (adv && func_s1 == FUNC_TICK) begin
			push.cnt = {1'b0, up_emit} + {1'b0, down_emit};
			if (!up_emit) begin
				push.r0 = r_dn;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_delay_q    <= INITIAL_DELAY_RESET;
			period_q        <= REPEAT_PERIOD_RESET;
			menu_held_q     <= 1'b0;
			menu_two_held_q <= 1'b0;
			up_held_q       <= 1'b0;
			up_fresh_q      <= 1'b0;
			up_dl_q         <= '0;
			down_held_q     <= 1'b0;
			down_fresh_q    <= 1'b0;
			down_dl_q       <= '0;
			level_q         <= LEVEL_RESET;
		end else begin
			if (adv && func_s1 == FUNC_KEY && ev_ok) begin
				unique case (code_s1)
					KEY_MENU:     menu_held_q <= on;
					KEY_MENU_TWO: menu_two_held_q <= on;
					KEY_UP: begin
						up_held_q  <= on;
						up_fresh_q <= on;
						if (val_s1 == VAL_PRESSED) begin
							up_dl_q <= arm_dl;
						end
					end
					KEY_DOWN: begin
						down_held_q  <= on;
						down_fresh_q <= on;
						if (val_s1 == VAL_PRESSED) begin
							down_dl_q <= arm_dl;
						end
					end
					default: ;
				endcase
			end
			if (adv && func_s1 == FUNC_TICK) begin
				level_q <= lvl_dn;
				// a fresh key consumes its fresh flag, a repeat advances the deadline
				if (up_due) begin
					if (up_fresh_q) begin
						up_fresh_q <= 1'b0;
					end else begin
						up_dl_q <= up_dl_q + TIME_W'(period_q);
					end
				end
				if (down_due) begin
					if (down_fresh_q) begin
						down_fresh_q <= 1'b0;
					end else begin
						down_dl_q <= down_dl_q + TIME_W'(period_q);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_INITIAL_DELAY: init_delay_q <= cfg.data;
					CFG_REPEAT_PERIOD: period_q <= cfg.data;
					CFG_START_VOLUME:  level_q <= start_lvl;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* design/kavs_fifo.sv */
// ----------------------------------------------------------------------------
// kavs_fifo: result queue
// Four-entry queue taking up to two result words per cycle and handing out
// one word per cycle on the output channel while result_out is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module kavs_fifo
	import kavs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire push_t  push,
	output logic        room,
	kavs_out_if.source  result_out
);

	res_t       mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;
	logic       pop;
	res_t       head;

	assign head              = mem_q[rd_q];
	assign result_out.valid  = (count_q != 3'd0);
	assign result_out.direction = head.direction;
	assign result_out.level  = head.level;
	assign result_out.percent = head.percent;
	assign result_out.last   = head.last;
	assign pop               = result_out.valid && result_out.ready;
	// keep space for a full tick
	assign room              = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push.cnt;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push.cnt} - {2'b00, pop};
		end
	end

endmodule

`default_nettype wire

/* design/kavs_checker.sv */
// ----------------------------------------------------------------------------
// kavs_checker: port-level checks of the volume stepper
// Watches the result channel for range, consistency and ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none

module kavs_checker
	import kavs_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       out_direction,
	input wire logic [4:0] out_level,
	input wire logic [6:0] out_percent,
	input wire logic       out_last
);

	// a stalled word keeps its level and direction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_level)
			&& $stable(out_direction))
		else $error("stalled result word changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_level <= LEVEL_MAX))
		else $error("level above maximum");

	a_pct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_percent == level_pct(out_level)))
		else $error("percent does not match level");

	// only the up step can precede another result of the same tick
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> (out_direction == DIR_UP))
		else $error("down result not last of tick");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind key_autorepeat_volume_stepper kavs_checker u_kavs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result_out.valid),
	.out_ready     (result_out.ready),
	.out_direction (result_out.direction),
	.out_level     (result_out.level),
	.out_percent   (result_out.percent),
	.out_last      (result_out.last)
);

`default_nettype wire
